// ===== rtl/deque_with_min_max_unit_defines.svh =====
// assertion helpers shared by the rtl
`ifndef DEQUE_WITH_MIN_MAX_UNIT_DEFINES_SVH
`define DEQUE_WITH_MIN_MAX_UNIT_DEFINES_SVH

// property must hold at every edge outside reset
`define DQMM_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define DQMM_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/dqmm_pkg.sv =====
package dqmm_pkg;

  // defaults for the top level parameters
  localparam int unsigned DepthDef     = 64;
  localparam int unsigned ValueBitsDef = 32;

  // fixed field widths of the channels
  localparam int unsigned ModeW   = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned FieldW  = 32;
  localparam int unsigned CountW  = 7;

  // operation codes
  typedef enum logic [ModeW-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_REPORT     = 3'd4
  } mode_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // request item
  typedef struct packed {
    logic [ModeW-1:0]         mode;
    logic signed [FieldW-1:0] item_value;
  } dqmm_req_t;

  // result item
  typedef struct packed {
    logic [StatusW-1:0]       status;
    logic signed [FieldW-1:0] front_value;
    logic signed [FieldW-1:0] back_value;
    logic signed [FieldW-1:0] min_value;
    logic signed [FieldW-1:0] max_value;
    logic [CountW-1:0]        entry_count;
    logic                     has_entries;
  } dqmm_rsp_t;

endpackage

// ===== rtl/dqmm_if.sv =====
// request channel
interface dqmm_req_if
  import dqmm_pkg::*;
();
  logic      valid;
  logic      ready;
  dqmm_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// result channel
interface dqmm_rsp_if
  import dqmm_pkg::*;
();
  logic      valid;
  logic      ready;
  dqmm_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/dqmm_ram.sv =====
module dqmm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/deque_with_min_max_unit.sv =====
// Bounded double-ended queue of signed values with min/max report.
// Channels: req_i (sink) carries an item with mode and item_value; rsp_o
// (source) returns one result item per request: status, front, back, min,
// max, entry count and a nonempty flag. Both use valid/ready; an item moves
// on a rising edge with valid and ready high.
// The result follows a scan over the ring memory for min, max, front and
// back: one entry read per cycle through the single read port, which has a
// registered read. The scan is skipped when the queue ends up empty. The
// unit takes no new request until the result of the last one has been
// loaded into the output register.
// req_i.ready is high while the unit is idle; a new request is taken while an
// earlier result still waits in the output register. If rsp_o is stalled
// the finished scan holds until the output register frees up.
// Reset (rst_ni low, asynchronous) empties the queue and drops any pending
// result; the ring memory itself is not cleared and needs no init pass.
module deque_with_min_max_unit
  import dqmm_pkg::*;
#(
  parameter int unsigned DEPTH      = DepthDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dqmm_req_if.sink  req_i,
  dqmm_rsp_if.source rsp_o
);

  `include "deque_with_min_max_unit_defines.svh"

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                       state_q;
  logic [IdxW-1:0]              front_q, front_d;
  logic [CntW-1:0]              count_q, count_d;
  logic [StatusW-1:0]           status_q, status_d;
  logic [IdxW-1:0]              rd_idx_q;
  logic [CntW-1:0]              iss_q;
  logic                         rd_pend_q, rd_first_q, rd_last_q;
  logic signed [VALUE_BITS-1:0] fv_q, bv_q, mn_q, mx_q;
  logic                         rsp_valid_q;
  dqmm_rsp_t                    rsp_q;

  logic                         accept;
  logic                         full, empty;
  logic [IdxW-1:0]              front_dec, front_inc, rd_idx_inc, back_slot;
  logic [SumW-1:0]              back_sum;
  logic                         ram_we, ram_re;
  logic [IdxW-1:0]              ram_waddr;
  logic signed [VALUE_BITS-1:0] push_val, rd_val;
  logic                         load_rsp;

  // narrow or widen a stored value to a 32-bit field
  function automatic logic signed [FieldW-1:0] to_field(
    input logic signed [VALUE_BITS-1:0] x
  );
    logic signed [63:0] w;
    w = 64'(x);
    return w[FieldW-1:0];
  endfunction

  assign accept   = req_i.valid && req_i.ready;
  assign full     = (count_q == CntW'(DEPTH));
  assign empty    = (count_q == '0);
  assign push_val = VALUE_BITS'(64'(req_i.data.item_value));

  // ring index arithmetic with wrap at DEPTH
  assign front_dec  = (front_q == '0) ? IdxW'(DEPTH - 1) : front_q - IdxW'(1);
  assign front_inc  = (front_q == IdxW'(DEPTH - 1)) ? '0 : front_q + IdxW'(1);
  assign rd_idx_inc = (rd_idx_q == IdxW'(DEPTH - 1)) ? '0 : rd_idx_q + IdxW'(1);
  assign back_sum   = SumW'(front_q) + SumW'(count_q);
  assign back_slot  = (back_sum >= SumW'(DEPTH)) ? IdxW'(back_sum - SumW'(DEPTH))
                                                 : IdxW'(back_sum);

  // operation decode and queue update
  always_comb begin
    front_d   = front_q;
    count_d   = count_q;
    status_d  = STAT_OK;
    ram_we    = 1'b0;
    ram_waddr = back_slot;
    unique case (req_i.data.mode)
      MODE_PUSH_BACK: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          ram_we  = accept;
          count_d = count_q + CntW'(1);
        end
      end
      MODE_PUSH_FRONT: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          ram_we    = accept;
          ram_waddr = front_dec;
          front_d   = front_dec;
          count_d   = count_q + CntW'(1);
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          count_d = count_q - CntW'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          front_d = front_inc;
          count_d = count_q - CntW'(1);
        end
      end
      default: begin
        status_d = STAT_OK;
      end
    endcase
  end

  // scan reads walk the ring from the front
  assign ram_re   = (state_q == S_SCAN) && (iss_q < count_q);
  assign load_rsp = (state_q == S_DONE) && (!rsp_valid_q || rsp_o.ready);

  dqmm_ram #(
    .Width (VALUE_BITS),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (push_val),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_val)
  );

  // sequencer, queue state, scan accumulators and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      status_q    <= STAT_OK;
      rd_idx_q    <= '0;
      iss_q       <= '0;
      rd_pend_q   <= 1'b0;
      rd_first_q  <= 1'b0;
      rd_last_q   <= 1'b0;
      fv_q        <= '0;
      bv_q        <= '0;
      mn_q        <= '0;
      mx_q        <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      if (rsp_valid_q && rsp_o.ready && !load_rsp) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            front_q  <= front_d;
            count_q  <= count_d;
            status_q <= status_d;
            rd_idx_q <= front_d;
            iss_q    <= '0;
            fv_q     <= '0;
            bv_q     <= '0;
            mn_q     <= '0;
            mx_q     <= '0;
            state_q  <= (count_d == '0) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          // issue side
          rd_pend_q <= ram_re;
          if (ram_re) begin
            iss_q      <= iss_q + CntW'(1);
            rd_idx_q   <= rd_idx_inc;
            rd_first_q <= (iss_q == '0);
            rd_last_q  <= (iss_q == count_q - CntW'(1));
          end
          // data side, handles each read in the cycle after its issue
          if (rd_pend_q) begin
            if (rd_first_q) begin
              fv_q <= rd_val;
              mn_q <= rd_val;
              mx_q <= rd_val;
            end else begin
              if (rd_val < mn_q) begin
                mn_q <= rd_val;
              end
              if (rd_val > mx_q) begin
                mx_q <= rd_val;
              end
            end
            if (rd_last_q) begin
              bv_q    <= rd_val;
              state_q <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (load_rsp) begin
            rsp_valid_q       <= 1'b1;
            rsp_q.status      <= status_q;
            rsp_q.front_value <= to_field(fv_q);
            rsp_q.back_value  <= to_field(bv_q);
            rsp_q.min_value   <= to_field(mn_q);
            rsp_q.max_value   <= to_field(mx_q);
            rsp_q.entry_count <= CountW'(count_q);
            rsp_q.has_entries <= (count_q != '0);
            state_q           <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // checks on the queue bookkeeping and the sequencer
  `DQMM_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CntW'(DEPTH), "count above depth")
  `DQMM_ASSERT_NEVER(a_front_range, clk_i, rst_ni, front_q > IdxW'(DEPTH - 1), "front out of ring")
  `DQMM_ASSERT_NEVER(a_idle_no_read, clk_i, rst_ni, (state_q == S_IDLE) && rd_pend_q, "idle read")
  `DQMM_ASSERT(a_rsp_from_done, clk_i, rst_ni, $rose(rsp_valid_q) |-> $past(load_rsp), "bad load")

endmodule
